// ----- rtl/pa_pkg.sv -----
// pa_pkg: types and constants shared by the primitive assembler files
// holds the transfer payload structs, mode codes and register map
// no dependencies
package pa_pkg;

  localparam int FIELD_W = 32;
  localparam int POS_W   = 32;
  localparam int MODE_W  = 3;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_PRIM_MODE = 1'b0;  // register index, taken from paddr[2]

  // primitive modes
  localparam logic [MODE_W-1:0] MODE_TRIANGLES = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TRI_STRIP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TRI_FAN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUADS     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUAD_STRIP = 3'd4;
  localparam logic [MODE_W-1:0] MODE_POLYGON   = 3'd5;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  typedef struct packed {
    logic [FIELD_W-1:0] vertex_index;
    logic               set_end;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] corner_index;
    logic [POS_W-1:0]   corner_number;
    logic               polygon_last;
  } out_item_t;

  // polygon handed from the assembler to the corner serialiser
  typedef struct packed {
    logic       emit;         // the vertex completes a polygon
    logic [1:0] last_corner;  // number of corners minus one
    logic       chain;        // polygon mode: corner number is the set position
    logic       set_end;
  } poly_ctl_t;

endpackage

// ----- rtl/pa_assemble.sv -----
// pa_assemble: assembly state (pivot, history, position, winding) and
// combinational selection of the corners completed by the incoming vertex
// depends on pa_pkg
module pa_assemble #(
  parameter int INDEX_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [pa_pkg::MODE_W-1:0]   mode,
  input  logic [INDEX_BITS-1:0]       vertex,
  input  logic                        set_end,
  output pa_pkg::poly_ctl_t           ctl,
  output logic [INDEX_BITS-1:0]       corner [4],
  output logic [pa_pkg::POS_W-1:0]    position
);
  import pa_pkg::*;

  logic [INDEX_BITS-1:0] pivot_r, pivot_nxt;
  logic [INDEX_BITS-1:0] hist0_r, hist1_r, hist2_r;
  logic [POS_W-1:0]      pos_r, pos_nxt, pos_adv;
  logic                  wind_r, wind_nxt;

  assign pos_adv  = (pos_r == POS_MAX) ? POS_MAX - POS_W'(1) : pos_r + POS_W'(1);
  assign position = pos_r;

  always_comb begin
    ctl.emit        = 1'b0;
    ctl.last_corner = 2'd2;
    ctl.chain       = 1'b0;
    ctl.set_end     = set_end;
    corner[0]       = hist1_r;
    corner[1]       = hist0_r;
    corner[2]       = vertex;
    corner[3]       = vertex;
    pos_nxt         = pos_adv;
    wind_nxt        = wind_r;
    pivot_nxt       = pivot_r;
    unique case (mode)
      MODE_TRIANGLES: begin
        if (pos_r >= POS_W'(2)) begin
          ctl.emit = 1'b1;
          pos_nxt  = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      MODE_QUADS: begin
        ctl.last_corner = 2'd3;
        corner[0] = hist2_r;
        corner[1] = hist1_r;
        corner[2] = hist0_r;
        if (pos_r >= POS_W'(3)) begin
          ctl.emit = 1'b1;
          pos_nxt  = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      MODE_TRI_STRIP: begin
        if (wind_r) begin
          corner[0] = vertex;
          corner[2] = hist1_r;
        end
        if (pos_r >= POS_W'(2)) begin
          ctl.emit = 1'b1;
          wind_nxt = ~wind_r;
        end
      end
      MODE_TRI_FAN: begin
        corner[0] = pivot_r;
        if (pos_r == '0) pivot_nxt = vertex;
        if (pos_r >= POS_W'(2)) ctl.emit = 1'b1;
      end
      MODE_QUAD_STRIP: begin
        ctl.last_corner = 2'd3;
        if (wind_r) begin
          corner[0] = vertex;
          corner[1] = hist0_r;
          corner[2] = hist1_r;
          corner[3] = hist2_r;
        end else begin
          corner[0] = hist2_r;
          corner[1] = hist1_r;
          corner[2] = hist0_r;
          corner[3] = vertex;
        end
        if (pos_r >= POS_W'(3) && pos_r[0]) begin
          ctl.emit = 1'b1;
          wind_nxt = ~wind_r;
        end
      end
      MODE_POLYGON: begin
        ctl.emit        = 1'b1;
        ctl.chain       = 1'b1;
        ctl.last_corner = 2'd0;
        corner[0]       = vertex;
        pos_nxt = (pos_r == POS_MAX) ? POS_MAX : pos_r + POS_W'(1);
      end
      default: begin
        // unused codes: nothing emitted, state still advances
      end
    endcase
    if (set_end) begin
      pos_nxt  = '0;
      wind_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pivot_r <= '0;
      hist0_r <= '0;
      hist1_r <= '0;
      hist2_r <= '0;
      pos_r   <= '0;
      wind_r  <= 1'b0;
    end else if (accept) begin
      pivot_r <= pivot_nxt;
      hist0_r <= vertex;
      hist1_r <= hist0_r;
      hist2_r <= hist1_r;
      pos_r   <= pos_nxt;
      wind_r  <= wind_nxt;
    end
  end

endmodule

// ----- rtl/pa_serialise.sv -----
// pa_serialise: polygon buffer that hands out one corner per transfer,
// followed by the result output register
// depends on pa_pkg
module pa_serialise #(
  parameter int INDEX_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  pa_pkg::poly_ctl_t        ctl,
  input  logic [INDEX_BITS-1:0]    corner [4],
  input  logic [pa_pkg::POS_W-1:0] position,
  output logic                     take,
  output logic                     out_valid,
  input  logic                     out_stall,
  output pa_pkg::out_item_t        out_data
);
  import pa_pkg::*;

  logic                  buf_valid_r;
  poly_ctl_t             ctl_r;
  logic [INDEX_BITS-1:0] corner_r [4];
  logic [POS_W-1:0]      pos_r;
  logic [1:0]            k_r;
  logic                  out_valid_r;
  out_item_t             out_data_r, out_data_nxt;
  logic                  out_load, done;

  assign out_load = buf_valid_r && (!out_valid_r || !out_stall);
  assign done     = out_load && (k_r == ctl_r.last_corner);
  assign take     = !buf_valid_r || done;

  always_comb begin
    out_data_nxt.corner_index = FIELD_W'(corner_r[k_r]);
    if (ctl_r.chain) begin
      out_data_nxt.corner_number = pos_r;
      out_data_nxt.polygon_last  = ctl_r.set_end;
    end else begin
      out_data_nxt.corner_number = POS_W'(k_r);
      out_data_nxt.polygon_last  = (k_r == ctl_r.last_corner);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      k_r         <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        buf_valid_r <= 1'b1;
        k_r         <= 2'd0;
      end else begin
        if (done) buf_valid_r <= 1'b0;
        if (out_load) k_r <= k_r + 2'd1;
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctl_r    <= ctl;
      corner_r <= corner;
      pos_r    <= position;
    end
    if (out_load) out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/primitive_assembler_core.sv -----
// primitive_assembler_core: an input transfer's first corner passes the polygon buffer, then the output register
// throughput one vertex a cycle, while the output does not stall and vertices complete
// nothing or one corner; a vertex that completes a triangle or quad holds the input until
// its corners have left, one per transfer, set by the single corner-wide output register
// synchronous active-low reset clears mode, assembly state and both valid flags
module primitive_assembler_core #(
  parameter int INDEX_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // vertex stream
  input  logic                           in_valid,
  output logic                           in_stall,
  input  pa_pkg::in_item_t               in_data,
  // corner stream
  output logic                           out_valid,
  input  logic                           out_stall,
  output pa_pkg::out_item_t              out_data,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pa_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [pa_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [pa_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                           pready
);
  import pa_pkg::*;

  logic [MODE_W-1:0]     mode_r;
  logic                  in_accept;
  logic                  take;
  poly_ctl_t             poly_ctl;
  logic [INDEX_BITS-1:0] poly_corner [4];
  logic [POS_W-1:0]      poly_pos;

  // register port: single mode register, always ready, read returns the mode
  assign pready = 1'b1;
  assign prdata = CFG_DATA_W'(mode_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_TRIANGLES;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_PRIM_MODE)) begin
      mode_r <= pwdata[MODE_W-1:0];
    end
  end

  // input is held off only while the polygon buffer still has corners
  // that will not leave this cycle
  assign in_stall  = !take;
  assign in_accept = in_valid && !in_stall;

  // state update and corner selection for the arriving vertex
  pa_assemble #(
    .INDEX_BITS (INDEX_BITS)
  ) u_assemble (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .mode     (mode_r),
    .vertex   (in_data.vertex_index[INDEX_BITS-1:0]),
    .set_end  (in_data.set_end),
    .ctl      (poly_ctl),
    .corner   (poly_corner),
    .position (poly_pos)
  );

  // polygon buffer and output register, one corner per transfer
  pa_serialise #(
    .INDEX_BITS (INDEX_BITS)
  ) u_serialise (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept && poly_ctl.emit),
    .ctl       (poly_ctl),
    .corner    (poly_corner),
    .position  (poly_pos),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/pa_checker.sv -----
// pa_checker: port-level checks on the primitive assembler, bound to the top level
// depends on pa_pkg and primitive_assembler_core
module pa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input pa_pkg::out_item_t             out_data,
  input logic [pa_pkg::CFG_DATA_W-1:0] prdata
);
  import pa_pkg::*;

  // a stalled corner stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled corner changed");

  // nothing comes out straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // corners of a triangle or quad follow back to back, numbered in order
  a_corner_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.polygon_last &&
    (prdata[MODE_W-1:0] != MODE_POLYGON) && (out_data.corner_number < POS_W'(3))
    |=> out_valid && (out_data.corner_number == $past(out_data.corner_number) + POS_W'(1)))
    else $error("polygon corners not contiguous");

endmodule

bind primitive_assembler_core pa_checker u_pa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .prdata    (prdata)
);

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking testbench for primitive_assembler_core
// depends on pa_pkg (payload structs, mode codes, register map) and the core itself
// drives vertex sets in every mode, predicts each corner and compares at the output
module tb_top;
  import pa_pkg::*;

  // the two codes that the mode register holds but that select no primitive
  localparam logic [MODE_W-1:0] MODE_UNUSED_A = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_B = 3'd7;
  localparam logic [CFG_ADDR_W-1:0] PRIM_MODE_ADDR = {REG_PRIM_MODE, 2'b00};
  // cycles allowed after the last corner for vertices that emit nothing
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_ITEMS  = 64;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  primitive_assembler_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow of the assembler: mode, fan pivot, last three indices, position, winding
  logic [MODE_W-1:0]  cur_mode;
  logic [FIELD_W-1:0] fan_pivot;
  logic [FIELD_W-1:0] recent_idx [3];  // [0] is the most recent vertex
  logic [POS_W-1:0]   set_pos;
  logic               winding_rev;

  out_item_t corner_q [$];  // corners still owed by the block, oldest first

  int mismatches = 0;
  int sent_count = 0;

  // sender pacing: bursts of random length, gaps of up to gap_max cycles
  int burst_left = 0;
  int gap_max    = 0;

  // receiver pacing: 0 never stalls, 1 random percentage, 2 rotating bit pattern
  int          stall_style   = 0;
  int          stall_pct     = 30;
  logic [15:0] stall_pattern = 16'h0000;
  logic [3:0]  pat_pos       = '0;
  int          hold_req      = 0;  // request for a long hold, taken up by the receiver
  int          hold_left     = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: stall pattern of its own, long holds counted here
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        1: out_stall <= ($urandom_range(0, 99) < stall_pct);
        2: begin
          out_stall <= stall_pattern[pat_pos];
          pat_pos = pat_pos + 4'd1;
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // corner checker: every accepted result is matched against the oldest expectation
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (corner_q.size() == 0) begin
        $error("unexpected corner: index %h number %0d last %b",
               out_data.corner_index, out_data.corner_number, out_data.polygon_last);
        mismatches++;
      end else begin
        want = corner_q.pop_front();
        if (out_data.corner_index !== want.corner_index) begin
          $error("corner_index: expected %h, got %h", want.corner_index,
                 out_data.corner_index);
          mismatches++;
        end
        if (out_data.corner_number !== want.corner_number) begin
          $error("corner_number: expected %0d, got %0d", want.corner_number,
                 out_data.corner_number);
          mismatches++;
        end
        if (out_data.polygon_last !== want.polygon_last) begin
          $error("polygon_last: expected %b, got %b", want.polygon_last,
                 out_data.polygon_last);
          mismatches++;
        end
      end
    end
  end

  // queue the corners of one polygon in order, the final one flagged
  task automatic push_polygon(input logic [FIELD_W-1:0] corners [4], input int n);
    out_item_t c;
    for (int k = 0; k < n; k++) begin
      c.corner_index  = corners[k];
      c.corner_number = POS_W'(k);
      c.polygon_last  = (k == n - 1);
      corner_q.push_back(c);
    end
  endtask

  // strips and fans keep parity when the position counter tops out
  function automatic logic [POS_W-1:0] step_pos(input logic [POS_W-1:0] p);
    return (p == POS_MAX) ? POS_MAX - 1 : p + 1;
  endfunction

  // predictor: one accepted vertex in, the corners it completes queued
  task automatic assemble_vertex(input in_item_t item);
    logic [FIELD_W-1:0] v;
    logic [FIELD_W-1:0] c [4];
    logic [POS_W-1:0]   p;
    logic [POS_W-1:0]   nxt;
    out_item_t          pc;
    v   = item.vertex_index;
    p   = set_pos;
    nxt = step_pos(p);
    case (cur_mode)
      MODE_TRIANGLES: begin
        if (p >= 2) begin
          c = '{recent_idx[1], recent_idx[0], v, '0};
          push_polygon(c, 3);
          nxt = '0;
        end else begin
          nxt = p + 1;
        end
      end
      MODE_QUADS: begin
        if (p >= 3) begin
          c = '{recent_idx[2], recent_idx[1], recent_idx[0], v};
          push_polygon(c, 4);
          nxt = '0;
        end else begin
          nxt = p + 1;
        end
      end
      MODE_TRI_STRIP: begin
        if (p >= 2) begin
          if (winding_rev) c = '{v, recent_idx[0], recent_idx[1], '0};
          else             c = '{recent_idx[1], recent_idx[0], v, '0};
          push_polygon(c, 3);
          winding_rev = ~winding_rev;
        end
      end
      MODE_TRI_FAN: begin
        if (p == 0) fan_pivot = v;
        if (p >= 2) begin
          c = '{fan_pivot, recent_idx[0], v, '0};
          push_polygon(c, 3);
        end
      end
      MODE_QUAD_STRIP: begin
        // emits on odd positions from the fourth vertex, direct then reversed
        if (p >= 3 && p[0]) begin
          if (winding_rev) c = '{v, recent_idx[0], recent_idx[1], recent_idx[2]};
          else             c = '{recent_idx[2], recent_idx[1], recent_idx[0], v};
          push_polygon(c, 4);
          winding_rev = ~winding_rev;
        end
      end
      MODE_POLYGON: begin
        // pass-through, numbered by set position, which saturates
        pc.corner_index  = v;
        pc.corner_number = p;
        pc.polygon_last  = item.set_end;
        corner_q.push_back(pc);
        nxt = (p == POS_MAX) ? POS_MAX : p + 1;
      end
      default: ;  // unused codes: count and history advance, nothing emitted
    endcase
    recent_idx[2] = recent_idx[1];
    recent_idx[1] = recent_idx[0];
    recent_idx[0] = v;
    if (item.set_end) begin
      set_pos     = '0;
      winding_rev = 1'b0;
    end else begin
      set_pos = nxt;
    end
  endtask

  function automatic logic [FIELD_W-1:0] rand_index();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {{(FIELD_W-1){1'b0}}, 1'b1} << $urandom_range(0, FIELD_W - 1);
      default: return $urandom;
    endcase
  endfunction

  // offer one vertex, hold it until the transfer, then maybe open a gap
  task automatic send_vertex(input logic [FIELD_W-1:0] idx, input logic last);
    in_item_t item;
    item.vertex_index = idx;
    item.set_end      = last;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    assemble_vertex(item);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 8);
      if (gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
      end
    end
  endtask

  // sender stops until every owed corner is in and the pipeline has settled
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (corner_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mode register write then read-back, only ever with the block idle
  task automatic write_prim_mode(input logic [MODE_W-1:0] mode);
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] want;
    wdata              = $urandom;  // upper bits must be ignored
    wdata[MODE_W-1:0]  = mode;
    want               = '0;
    want[MODE_W-1:0]   = mode;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PRIM_MODE_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_mode = mode;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $error("prim_mode: expected %h, got %h", want, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // reset mode is triangles; extremes of the index; an incomplete triangle is dropped
  task automatic test_reset_triangles();
    send_vertex('0, 1'b0);
    send_vertex('1, 1'b0);
    send_vertex(32'h0000_0001, 1'b0);
    send_vertex(32'hA5A5_A5A5, 1'b1);
  endtask

  // strip alternates winding, fan pivots on the first vertex of the set
  task automatic test_strip_and_fan();
    write_prim_mode(MODE_TRI_STRIP);
    send_vertex(32'h0000_0010, 1'b0);
    send_vertex(32'h0000_0011, 1'b0);
    send_vertex(32'hFFFF_FFFE, 1'b0);
    send_vertex(32'h8000_0000, 1'b1);
    write_prim_mode(MODE_TRI_FAN);
    send_vertex(32'h5A5A_5A5A, 1'b0);
    send_vertex(32'h0000_0021, 1'b0);
    send_vertex(32'h0000_0022, 1'b0);
    send_vertex(32'h7FFF_FFFF, 1'b1);
  endtask

  // quad strip: direct quad on the fourth vertex, reversed on the sixth
  task automatic test_quad_strip();
    write_prim_mode(MODE_QUAD_STRIP);
    for (int i = 0; i < 6; i++) send_vertex(32'h0000_0100 + i, i == 5);
  endtask

  // polygon numbering and end flag, then the two codes that emit nothing
  task automatic test_polygon_and_unused();
    write_prim_mode(MODE_POLYGON);
    send_vertex(32'hDEAD_BEEF, 1'b0);
    send_vertex(32'h0123_4567, 1'b1);
    write_prim_mode(MODE_UNUSED_A);
    send_vertex(32'h0000_0200, 1'b0);
    write_prim_mode(MODE_UNUSED_B);
    send_vertex(32'h0000_0201, 1'b1);
  endtask

  // a full quad, then a quad count carried into triangle mode emits at once
  task automatic test_mode_switch_mid_set();
    write_prim_mode(MODE_QUADS);
    for (int i = 0; i < 7; i++) send_vertex(32'h0000_0300 + i, i == 3);
    write_prim_mode(MODE_TRIANGLES);
    send_vertex(32'h0000_0310, 1'b1);
  endtask

  // long receiver hold with the sender pushing; block fills and stalls its input
  task automatic test_backpressure();
    gap_max     = 0;
    stall_style = 0;
    write_prim_mode(MODE_QUADS);
    hold_req = 200;
    for (int i = 0; i < 24; i++) send_vertex(rand_index(), i == 23);
    wait_drained();
    write_prim_mode(MODE_POLYGON);
    hold_req = 80;
    for (int i = 0; i < 12; i++) send_vertex(rand_index(), i == 11);
    wait_drained();
  endtask

  // random sets, mostly well formed, some broken by stray or missing set ends
  task automatic test_random_sets(input int n_items);
    int   start;
    int   len;
    int   pick;
    logic last;
    start = sent_count;
    while (sent_count - start < n_items) begin
      pick = $urandom_range(0, 2);
      gap_max       = (pick == 0) ? 0 : (pick == 1) ? 3 : 8;
      stall_style   = $urandom_range(0, 2);
      stall_pct     = $urandom_range(10, 60);
      stall_pattern = 16'($urandom);
      if ($urandom_range(0, 1))
        write_prim_mode(MODE_W'($urandom_range(MODE_TRIANGLES, MODE_POLYGON)));
      case (cur_mode)
        MODE_TRIANGLES:  len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8)
                                                           : 3 * $urandom_range(1, 4);
        MODE_QUADS:      len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8)
                                                           : 4 * $urandom_range(1, 3);
        MODE_TRI_STRIP,
        MODE_TRI_FAN:    len = $urandom_range(3, 10);
        MODE_QUAD_STRIP: len = $urandom_range(4, 12);
        default:         len = $urandom_range(1, 8);
      endcase
      for (int i = 0; i < len; i++) begin
        if (i == len - 1) last = ($urandom_range(0, 9) != 0);
        else              last = ($urandom_range(0, 19) == 0);
        send_vertex(rand_index(), last);
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    cur_mode    = MODE_TRIANGLES;
    fan_pivot   = '0;
    recent_idx  = '{'0, '0, '0};
    set_pos     = '0;
    winding_rev = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with mild pacing on both sides
    gap_max       = 2;
    stall_style   = 2;
    stall_pattern = 16'b0110_0010_1100_0100;
    test_reset_triangles();
    test_strip_and_fan();
    test_quad_strip();
    test_polygon_and_unused();
    test_mode_switch_mid_set();
    test_backpressure();
    test_random_sets(RANDOM_ITEMS);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
